>>> hdl/sliding_mode_emf_observer_macros.svh
// Assertion macros for the sliding mode EMF observer.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SLIDING_MODE_EMF_OBSERVER_MACROS_SVH
`define SLIDING_MODE_EMF_OBSERVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SMO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SMO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/smo_pkg.sv
// Shared types, constants and helpers for the sliding mode EMF observer.
// No dependencies; used by smo_ctrl, smo_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package smo_pkg;

   localparam int DATA_W   = 16;
   localparam int RETAIN_W = 19;
   localparam int DRIVE_W  = 24;
   localparam int GAIN_W   = 15;
   localparam int FILT_W   = 17;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 24;
   localparam int MUL_A_W  = 25;
   localparam int MUL_B_W  = 18;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int WIDE_W   = 48;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_RETAIN     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_TO_CURRENT = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_GAIN        = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EMF_FILTER_FACTOR  = 8'd3;

   // reset values
   localparam logic [RETAIN_W-1:0] RETAIN_RST = 19'd262144;
   localparam logic [DRIVE_W-1:0]  DRIVE_RST  = 24'd0;
   localparam logic [GAIN_W-1:0]   GAIN_RST   = 15'd0;
   localparam logic [FILT_W-1:0]   FILT_RST   = 17'd6554;
   localparam logic [FILT_W-1:0]   FILT_ONE   = 17'd65536;

   // boundary layer of one ampere in Q5.10
   localparam logic signed [DATA_W:0] ERR_LIMIT = 17'sd1024;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RETAIN,
      ST_DRIVE,
      ST_EST,
      ST_GAIN,
      ST_RAW,
      ST_NEW_WT,
      ST_OLD_WT,
      ST_FILT,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_RETAIN,
      MUL_DRIVE,
      MUL_GAIN,
      MUL_NEW_WT,
      MUL_OLD_WT
   } mul_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        axis;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        est_load;
      logic        raw_load;
      logic        filt_load;
      logic        out_load;
   } cmd_type;

   function automatic logic signed [DATA_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 48'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -48'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/smo_ctrl.sv
// Sequencer for the observer: walks both axes through the shared multiplier.
// Depends on smo_pkg; drives smo_datapath through smo_pkg::cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module smo_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output smo_pkg::cmd_type     cmd
);

   smo_pkg::state_type state_ff, state_in;
   logic axis_ff, axis_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      case (state_ff)
         smo_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = smo_pkg::ST_RETAIN;
               axis_in  = 1'b0;
            end
         end
         smo_pkg::ST_RETAIN: state_in = smo_pkg::ST_DRIVE;
         smo_pkg::ST_DRIVE:  state_in = smo_pkg::ST_EST;
         smo_pkg::ST_EST:    state_in = smo_pkg::ST_GAIN;
         smo_pkg::ST_GAIN:   state_in = smo_pkg::ST_RAW;
         smo_pkg::ST_RAW:    state_in = smo_pkg::ST_NEW_WT;
         smo_pkg::ST_NEW_WT: state_in = smo_pkg::ST_OLD_WT;
         smo_pkg::ST_OLD_WT: state_in = smo_pkg::ST_FILT;
         smo_pkg::ST_FILT: begin
            if (!axis_ff) begin
               state_in = smo_pkg::ST_RETAIN;
               axis_in  = 1'b1;
            end else begin
               state_in = smo_pkg::ST_DONE;
            end
         end
         smo_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = smo_pkg::ST_IDLE;
            end
         end
         default: state_in = smo_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = smo_pkg::MUL_NONE;
      cmd.axis      = axis_ff;
      req_stall     = 1'b1;
      case (state_ff)
         smo_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         smo_pkg::ST_RETAIN: cmd.mul_sel = smo_pkg::MUL_RETAIN;
         smo_pkg::ST_DRIVE: begin
            cmd.mul_sel  = smo_pkg::MUL_DRIVE;
            cmd.acc_load = 1'b1;
         end
         smo_pkg::ST_EST:    cmd.est_load = 1'b1;
         smo_pkg::ST_GAIN:   cmd.mul_sel  = smo_pkg::MUL_GAIN;
         smo_pkg::ST_RAW:    cmd.raw_load = 1'b1;
         smo_pkg::ST_NEW_WT: cmd.mul_sel  = smo_pkg::MUL_NEW_WT;
         smo_pkg::ST_OLD_WT: begin
            cmd.mul_sel  = smo_pkg::MUL_OLD_WT;
            cmd.acc_load = 1'b1;
         end
         smo_pkg::ST_FILT:   cmd.filt_load = 1'b1;
         smo_pkg::ST_DONE:   cmd.out_load  = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smo_pkg::ST_IDLE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/smo_datapath.sv
// Observer datapath: config registers, shared 25x18 multiplier, per-axis state.
// Depends on smo_pkg; sequenced by smo_ctrl through smo_pkg::cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module smo_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write,
   input  wire logic [smo_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [smo_pkg::CSR_DAT_W-1:0]         csr_wdata,
   input  wire smo_pkg::cmd_type                      cmd,
   input  wire logic signed [smo_pkg::DATA_W-1:0]     req_volt_alpha,
   input  wire logic signed [smo_pkg::DATA_W-1:0]     req_volt_beta,
   input  wire logic signed [smo_pkg::DATA_W-1:0]     req_meas_cur_alpha,
   input  wire logic signed [smo_pkg::DATA_W-1:0]     req_meas_cur_beta,
   output logic signed [smo_pkg::DATA_W-1:0]          rsp_est_cur_alpha,
   output logic signed [smo_pkg::DATA_W-1:0]          rsp_est_cur_beta,
   output logic signed [smo_pkg::DATA_W-1:0]          rsp_raw_emf_alpha,
   output logic signed [smo_pkg::DATA_W-1:0]          rsp_raw_emf_beta,
   output logic signed [smo_pkg::DATA_W-1:0]          rsp_filt_emf_alpha,
   output logic signed [smo_pkg::DATA_W-1:0]          rsp_filt_emf_beta
);

   localparam int DW = smo_pkg::DATA_W;
   localparam int PW = smo_pkg::PROD_W;
   localparam int WW = smo_pkg::WIDE_W;

   // configuration
   logic [smo_pkg::RETAIN_W-1:0] retain_ff;
   logic [smo_pkg::DRIVE_W-1:0]  drive_ff;
   logic [smo_pkg::GAIN_W-1:0]   gain_ff;
   logic [smo_pkg::FILT_W-1:0]   ffac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retain_ff <= smo_pkg::RETAIN_RST;
         drive_ff  <= smo_pkg::DRIVE_RST;
         gain_ff   <= smo_pkg::GAIN_RST;
         ffac_ff   <= smo_pkg::FILT_RST;
      end else if (csr_write) begin
         case (csr_index)
            smo_pkg::CSR_CURRENT_RETAIN:     retain_ff <= csr_wdata[smo_pkg::RETAIN_W-1:0];
            smo_pkg::CSR_VOLTAGE_TO_CURRENT: drive_ff  <= csr_wdata[smo_pkg::DRIVE_W-1:0];
            smo_pkg::CSR_SWITCH_GAIN:        gain_ff   <= csr_wdata[smo_pkg::GAIN_W-1:0];
            smo_pkg::CSR_EMF_FILTER_FACTOR:  ffac_ff   <= csr_wdata[smo_pkg::FILT_W-1:0];
            default: ;
         endcase
      end
   end

   // weights above one clamp to a straight pass-through
   logic [smo_pkg::FILT_W-1:0] new_wt, old_wt;
   assign new_wt = (ffac_ff > smo_pkg::FILT_ONE) ? smo_pkg::FILT_ONE : ffac_ff;
   assign old_wt = smo_pkg::FILT_ONE - new_wt;

   // request and observer state
   logic signed [DW-1:0] volt_ff [2];
   logic signed [DW-1:0] meas_ff [2];
   logic signed [DW-1:0] est_ff  [2];
   logic signed [DW-1:0] filt_ff [2];
   logic signed [DW-1:0] raw_hold_ff [2];
   logic signed [DW-1:0] inew_ff, inew_in;
   logic signed [DW-1:0] raw_ff, raw_in;
   logic signed [DW-1:0] filt_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [PW-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         volt_ff[0] <= req_volt_alpha;
         volt_ff[1] <= req_volt_beta;
         meas_ff[0] <= req_meas_cur_alpha;
         meas_ff[1] <= req_meas_cur_beta;
      end
   end

   logic signed [DW-1:0] cur_volt, cur_meas, cur_est, cur_filt;
   assign cur_volt = volt_ff[cmd.axis];
   assign cur_meas = meas_ff[cmd.axis];
   assign cur_est  = est_ff[cmd.axis];
   assign cur_filt = filt_ff[cmd.axis];

   logic signed [DW:0] drive_diff, err;
   assign drive_diff = {cur_volt[DW-1], cur_volt} - {cur_filt[DW-1], cur_filt};
   assign err        = {inew_ff[DW-1], inew_ff} - {cur_meas[DW-1], cur_meas};

   // shared multiplier: unsigned coefficient times signed sample
   logic signed [smo_pkg::MUL_A_W-1:0] mul_a;
   logic signed [smo_pkg::MUL_B_W-1:0] mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         smo_pkg::MUL_RETAIN: begin
            mul_a = $signed({6'd0, retain_ff});
            mul_b = $signed({{2{cur_est[DW-1]}}, cur_est});
         end
         smo_pkg::MUL_DRIVE: begin
            mul_a = $signed({1'b0, drive_ff});
            mul_b = $signed({drive_diff[DW], drive_diff});
         end
         smo_pkg::MUL_GAIN: begin
            mul_a = $signed({10'd0, gain_ff});
            mul_b = $signed({err[DW], err});
         end
         smo_pkg::MUL_NEW_WT: begin
            mul_a = $signed({8'd0, new_wt});
            mul_b = $signed({{2{raw_ff[DW-1]}}, raw_ff});
         end
         smo_pkg::MUL_OLD_WT: begin
            mul_a = $signed({8'd0, old_wt});
            mul_b = $signed({{2{cur_filt[DW-1]}}, cur_filt});
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_sel != smo_pkg::MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_ff;
      end
   end

   // current estimate: retain*est + (drive*diff << 4), rounded at bit 18
   logic signed [WW-1:0] est_sum, est_shift;
   assign est_sum = {{(WW-PW){acc_ff[PW-1]}}, acc_ff}
                  + {{(WW-PW-4){prod_ff[PW-1]}}, prod_ff, 4'd0}
                  + 48'sd131072;
   assign est_shift = est_sum >>> 18;
   assign inew_in   = smo_pkg::sat16(est_shift);

   // switching function with the one-ampere boundary layer
   logic signed [PW-1:0] lin_sum, lin_shift;
   assign lin_sum   = prod_ff + 43'sd512;
   assign lin_shift = lin_sum >>> 10;

   always_comb begin
      if (err > smo_pkg::ERR_LIMIT) begin
         raw_in = $signed({1'b0, gain_ff});
      end else if (err < -smo_pkg::ERR_LIMIT) begin
         raw_in = -$signed({1'b0, gain_ff});
      end else begin
         raw_in = lin_shift[DW-1:0];
      end
   end

   // low-pass: new*raw + old*filt, rounded at bit 16
   logic signed [WW-1:0] filt_sum, filt_shift;
   assign filt_sum = {{(WW-PW){acc_ff[PW-1]}}, acc_ff}
                   + {{(WW-PW){prod_ff[PW-1]}}, prod_ff}
                   + 48'sd32768;
   assign filt_shift = filt_sum >>> 16;
   assign filt_in    = smo_pkg::sat16(filt_shift);

   always_ff @(posedge clock) begin
      if (cmd.est_load) begin
         inew_ff <= inew_in;
      end
      if (cmd.raw_load) begin
         raw_ff <= raw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff[0]  <= '0;
         est_ff[1]  <= '0;
         filt_ff[0] <= '0;
         filt_ff[1] <= '0;
      end else if (cmd.filt_load) begin
         est_ff[cmd.axis]  <= inew_ff;
         filt_ff[cmd.axis] <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.filt_load) begin
         raw_hold_ff[cmd.axis] <= raw_ff;
      end
   end

   // output register
   logic signed [DW-1:0] out_est_ff [2];
   logic signed [DW-1:0] out_raw_ff [2];
   logic signed [DW-1:0] out_filt_ff [2];

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_est_ff[0]  <= est_ff[0];
         out_est_ff[1]  <= est_ff[1];
         out_raw_ff[0]  <= raw_hold_ff[0];
         out_raw_ff[1]  <= raw_hold_ff[1];
         out_filt_ff[0] <= filt_ff[0];
         out_filt_ff[1] <= filt_ff[1];
      end
   end

   assign rsp_est_cur_alpha  = out_est_ff[0];
   assign rsp_est_cur_beta   = out_est_ff[1];
   assign rsp_raw_emf_alpha  = out_raw_ff[0];
   assign rsp_raw_emf_beta   = out_raw_ff[1];
   assign rsp_filt_emf_alpha = out_filt_ff[0];
   assign rsp_filt_emf_beta  = out_filt_ff[1];

endmodule

`default_nettype wire

>>> hdl/sliding_mode_emf_observer.sv
// A request is accepted only in idle; rsp_valid rises once both axes are done and the
// output register is loaded, and no new request is taken before then. The single 25x18
// multiplier takes five products per axis, eight sequencer steps per axis plus load/unload.
// Reset (synchronous, active high): registers to their defaults, current
// estimates and filtered EMF to zero, no response pending.
// Top level of the sliding mode EMF observer; depends on smo_pkg, smo_ctrl,
// smo_datapath and sliding_mode_emf_observer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_mode_emf_observer_macros.svh"

module sliding_mode_emf_observer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [smo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [smo_pkg::CSR_DAT_W-1:0]      csr_wdata,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [smo_pkg::DATA_W-1:0]  req_volt_alpha,
   input  wire logic signed [smo_pkg::DATA_W-1:0]  req_volt_beta,
   input  wire logic signed [smo_pkg::DATA_W-1:0]  req_meas_cur_alpha,
   input  wire logic signed [smo_pkg::DATA_W-1:0]  req_meas_cur_beta,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [smo_pkg::DATA_W-1:0]       rsp_est_cur_alpha,
   output logic signed [smo_pkg::DATA_W-1:0]       rsp_est_cur_beta,
   output logic signed [smo_pkg::DATA_W-1:0]       rsp_raw_emf_alpha,
   output logic signed [smo_pkg::DATA_W-1:0]       rsp_raw_emf_beta,
   output logic signed [smo_pkg::DATA_W-1:0]       rsp_filt_emf_alpha,
   output logic signed [smo_pkg::DATA_W-1:0]       rsp_filt_emf_beta
);

   smo_pkg::cmd_type cmd;

   // User must change registers only between requests (unchecked); the port never stalls.
   assign csr_ready = 1'b1;

   // Sequencer: per axis, retain product, drive product, estimate,
   // gain product, switching output, two filter products, filter update.
   smo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Datapath: config registers, shared multiplier, observer state and the
   // output register that parts the response side from the next request.
   smo_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .req_volt_alpha     (req_volt_alpha),
      .req_volt_beta      (req_volt_beta),
      .req_meas_cur_alpha (req_meas_cur_alpha),
      .req_meas_cur_beta  (req_meas_cur_beta),
      .rsp_est_cur_alpha  (rsp_est_cur_alpha),
      .rsp_est_cur_beta   (rsp_est_cur_beta),
      .rsp_raw_emf_alpha  (rsp_raw_emf_alpha),
      .rsp_raw_emf_beta   (rsp_raw_emf_beta),
      .rsp_filt_emf_alpha (rsp_filt_emf_alpha),
      .rsp_filt_emf_beta  (rsp_filt_emf_beta)
   );

   // an accepted request keeps the block busy on the next cycle
   `SMO_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request accepted but block not busy")
   // a response appears only through an output load
   `SMO_ASSERT_NOW(a_rsp_from_load, clock, reset, $rose(rsp_valid), $past(cmd.out_load), "response raised without output load")
   // a pending stalled response is never overwritten
   `SMO_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.out_load, !(rsp_valid && rsp_stall), "output load over a stalled response")

endmodule

`default_nettype wire

>>> dv/tb_sliding_mode_emf_observer.sv
// Self-checking testbench for sliding_mode_emf_observer: directed table, then random requests.
// Checks each response against a hand-typed row or a fixed-point predictor in this file.
// Depends on smo_pkg and the sliding_mode_emf_observer RTL.
`timescale 1ns / 1ps

module tb_sliding_mode_emf_observer;

   localparam int DATA_W    = smo_pkg::DATA_W;
   localparam int CSR_IDX_W = smo_pkg::CSR_IDX_W;
   localparam int CSR_DAT_W = smo_pkg::CSR_DAT_W;
   localparam int RETAIN_W  = smo_pkg::RETAIN_W;
   localparam int DRIVE_W   = smo_pkg::DRIVE_W;
   localparam int GAIN_W    = smo_pkg::GAIN_W;
   localparam int FILT_W    = smo_pkg::FILT_W;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int HOLD_OFF_CYCLES = 300;   // long response stall to back up the pipeline
   localparam int ITEMS_PER_PHASE = 138;   // eight phases, about 1100 requests
   localparam int NUM_PHASES = 8;
   localparam int SETTLE_CYCLES = 40;      // a margin longer than the request-to-response latency

   // register indexes outside the list; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 8'd255;

   // fixed-point constants of the observer
   localparam longint ONE_AMP   = 1024;    // boundary layer, Q5.10
   localparam longint UNITY_Q16 = 65536;   // filter weight of one

   typedef struct packed {
      logic signed [DATA_W-1:0] va;
      logic signed [DATA_W-1:0] vb;
      logic signed [DATA_W-1:0] ia;
      logic signed [DATA_W-1:0] ib;
   } obs_request_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] est_a;
      logic signed [DATA_W-1:0] est_b;
      logic signed [DATA_W-1:0] raw_a;
      logic signed [DATA_W-1:0] raw_b;
      logic signed [DATA_W-1:0] filt_a;
      logic signed [DATA_W-1:0] filt_b;
   } obs_result_type;

   // one row of the directed table: either a register write or a request,
   // a request optionally carrying a hand-typed response
   typedef struct {
      bit                   is_write;
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DAT_W-1:0] wdata;
      obs_request_type      rq;
      bit                   typed;
      obs_result_type       want;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;
   logic req_valid;
   logic req_stall;
   logic signed [DATA_W-1:0] req_volt_alpha;
   logic signed [DATA_W-1:0] req_volt_beta;
   logic signed [DATA_W-1:0] req_meas_cur_alpha;
   logic signed [DATA_W-1:0] req_meas_cur_beta;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [DATA_W-1:0] rsp_est_cur_alpha;
   logic signed [DATA_W-1:0] rsp_est_cur_beta;
   logic signed [DATA_W-1:0] rsp_raw_emf_alpha;
   logic signed [DATA_W-1:0] rsp_raw_emf_beta;
   logic signed [DATA_W-1:0] rsp_filt_emf_alpha;
   logic signed [DATA_W-1:0] rsp_filt_emf_beta;

   sliding_mode_emf_observer DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_volt_alpha     (req_volt_alpha),
      .req_volt_beta      (req_volt_beta),
      .req_meas_cur_alpha (req_meas_cur_alpha),
      .req_meas_cur_beta  (req_meas_cur_beta),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_est_cur_alpha  (rsp_est_cur_alpha),
      .rsp_est_cur_beta   (rsp_est_cur_beta),
      .rsp_raw_emf_alpha  (rsp_raw_emf_alpha),
      .rsp_raw_emf_beta   (rsp_raw_emf_beta),
      .rsp_filt_emf_alpha (rsp_filt_emf_alpha),
      .rsp_filt_emf_beta  (rsp_filt_emf_beta)
   );

   // ---------------------------------------------------------------------
   // Predictor: register copies and observer state, reset values
   // ---------------------------------------------------------------------
   longint retain_q18  = 262144;
   longint drive_q16   = 0;
   longint gain_q8     = 0;
   longint filt_weight = 6554;
   longint est_cur_a   = 0;
   longint est_cur_b   = 0;
   longint filt_emf_a  = 0;
   longint filt_emf_b  = 0;

   obs_result_type pending_estimates[$];   // predicted responses, oldest first
   dir_row_type    directed_rows[$];
   obs_result_type head;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;      // chance per cycle that the sender idles
   int          rsp_stall_pct = 0;      // chance per cycle that the receiver stalls
   int          hold_left = 0;          // remaining cycles of a forced response stall

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // One axis of the observer: Euler current step, saturation switching
   // function with a one-ampere boundary layer, then the EMF low-pass.
   // Rounding is add-half-then-floor; >>> on longint floors.
   function automatic void advance_axis(input longint u, input longint meas,
                                        input longint est, input longint filt,
                                        output longint new_est, output longint raw,
                                        output longint new_filt);
      longint acc;
      longint err;
      longint f;
      acc = retain_q18 * est + drive_q16 * (u - filt) * 16;
      new_est = clamp16((acc + (longint'(1) <<< 17)) >>> 18);
      err = new_est - meas;
      if (err > ONE_AMP)
         raw = gain_q8;
      else if (err < -ONE_AMP)
         raw = -gain_q8;
      else
         raw = (gain_q8 * err + 512) >>> 10;
      // weights above one behave as a straight pass-through
      f = (filt_weight > UNITY_Q16) ? UNITY_Q16 : filt_weight;
      new_filt = clamp16((f * raw + (UNITY_Q16 - f) * filt + 32768) >>> 16);
   endfunction

   // advance both axes for an accepted request and return the response
   function automatic obs_result_type observe(input obs_request_type rq);
      obs_result_type r;
      longint ne;
      longint raw;
      longint nf;
      advance_axis(rq.va, rq.ia, est_cur_a, filt_emf_a, ne, raw, nf);
      est_cur_a = ne;
      filt_emf_a = nf;
      r.est_a = 16'(ne);
      r.raw_a = 16'(raw);
      r.filt_a = 16'(nf);
      advance_axis(rq.vb, rq.ib, est_cur_b, filt_emf_b, ne, raw, nf);
      est_cur_b = ne;
      filt_emf_b = nf;
      r.est_b = 16'(ne);
      r.raw_b = 16'(raw);
      r.filt_b = 16'(nf);
      return r;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DAT_W-1:0] data);
      case (idx)
         smo_pkg::CSR_CURRENT_RETAIN:     retain_q18  = longint'(data[RETAIN_W-1:0]);
         smo_pkg::CSR_VOLTAGE_TO_CURRENT: drive_q16   = longint'(data[DRIVE_W-1:0]);
         smo_pkg::CSR_SWITCH_GAIN:        gain_q8     = longint'(data[GAIN_W-1:0]);
         smo_pkg::CSR_EMF_FILTER_FACTOR:  filt_weight = longint'(data[FILT_W-1:0]);
         default: ;   // unlisted index: no effect
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Random request generation
   // ---------------------------------------------------------------------
   function automatic logic signed [DATA_W-1:0] random_volt();
      if ($urandom_range(99) < 80)
         return 16'(int'($urandom_range(6000)) - 3000);
      return 16'($urandom);
   endfunction

   // Most measurements sit near the next estimate so the switching function
   // spends time in its linear band; the rest are full range or corners.
   function automatic logic signed [DATA_W-1:0] random_meas(input longint next_est);
      int corners[7] = '{-32768, -1024, -1, 0, 1, 1024, 32767};
      int pick;
      pick = $urandom_range(99);
      if (pick < 65)
         return 16'(clamp16(next_est + int'($urandom_range(3000)) - 1500));
      if (pick < 85)
         return 16'($urandom);
      return 16'(corners[$urandom_range(6)]);
   endfunction

   // the estimate update ignores the measurement, so a look-ahead with the
   // current predictor state tells where the next estimate lands
   function automatic obs_request_type random_request();
      obs_request_type rq;
      longint ne;
      longint raw;
      longint nf;
      rq.va = random_volt();
      rq.vb = random_volt();
      advance_axis(rq.va, 0, est_cur_a, filt_emf_a, ne, raw, nf);
      rq.ia = random_meas(ne);
      advance_axis(rq.vb, 0, est_cur_b, filt_emf_b, ne, raw, nf);
      rq.ib = random_meas(ne);
      return rq;
   endfunction

   // ---------------------------------------------------------------------
   // Directed table builders
   // ---------------------------------------------------------------------
   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DAT_W-1:0] data);
      dir_row_type row;
      row = '{default: '0};
      row.is_write = 1'b1;
      row.index = idx;
      row.wdata = data;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_item(input int va, input int vb, input int ia, input int ib);
      dir_row_type row;
      row = '{default: '0};
      row.rq = {16'(va), 16'(vb), 16'(ia), 16'(ib)};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(input int va, input int vb, input int ia, input int ib,
                                       input int ea, input int eb, input int ra, input int rb,
                                       input int fa, input int fb);
      add_item(va, vb, ia, ib);
      directed_rows[$].typed = 1'b1;
      directed_rows[$].want = {16'(ea), 16'(eb), 16'(ra), 16'(rb), 16'(fa), 16'(fb)};
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // Offer one request, idling first at the current rate. Valid stays high
   // until the request is taken; the prediction is made at that edge.
   task automatic send_request(input obs_request_type rq, input bit typed,
                               input obs_result_type want);
      obs_result_type predicted;
      if (csr_valid)
         csr_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_volt_alpha     <= rq.va;
      req_volt_beta      <= rq.vb;
      req_meas_cur_alpha <= rq.ia;
      req_meas_cur_beta  <= rq.ib;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = observe(rq);
      // hand-typed rows still advance the predictor state
      pending_estimates.push_back(typed ? want : predicted);
   endtask

   // stop sending and wait until every predicted response has arrived
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_estimates.size() != 0)
         @(posedge clock);
   endtask

   // valid is left high; the next request or write takes it from there
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      apply_register(idx, data);
   endtask

   // Register setting for one random phase: plausible motor values in half of
   // the phases, all ones and all zeros once each, fully random twice.
   task automatic configure_phase(input int phase);
      logic [CSR_DAT_W-1:0] vals[4];
      case (phase)
         1: vals = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
         5: vals = '{24'h0, 24'h0, 24'h0, 24'h0};
         3, 7: vals = '{24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)};
         default: begin
            vals[0] = 24'(262144 - $urandom_range(4000));
            vals[1] = 24'($urandom_range(4000));
            vals[2] = 24'($urandom_range(6000, 200));
            vals[3] = 24'($urandom_range(30000, 500));
         end
      endcase
      drain();
      write_reg(smo_pkg::CSR_CURRENT_RETAIN, vals[0]);
      write_reg(smo_pkg::CSR_VOLTAGE_TO_CURRENT, vals[1]);
      write_reg(smo_pkg::CSR_SWITCH_GAIN, vals[2]);
      write_reg(smo_pkg::CSR_EMF_FILTER_FACTOR, vals[3]);
      write_reg(8'($urandom_range(255, 4)), 24'($urandom));
   endtask

   task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
                              input logic signed [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Clock, cycle limit and response monitor
   // ---------------------------------------------------------------------
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Responses are taken at the edge where valid is high and stall low; the
   // stall for the next cycle is chosen here, or forced during a hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_estimates.size() == 0) begin
            $display("%0t: response with none outstanding", $time);
            mismatches++;
         end else begin
            head = pending_estimates.pop_front();
            check_field("est_cur_alpha", head.est_a, rsp_est_cur_alpha);
            check_field("est_cur_beta", head.est_b, rsp_est_cur_beta);
            check_field("raw_emf_alpha", head.raw_a, rsp_raw_emf_alpha);
            check_field("raw_emf_beta", head.raw_b, rsp_raw_emf_beta);
            check_field("filt_emf_alpha", head.filt_a, rsp_filt_emf_alpha);
            check_field("filt_emf_beta", head.filt_b, rsp_filt_emf_beta);
         end
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int idle_send[4] = '{0, 56, 0, 9};
      int idle_rsp[4]  = '{0, 0, 56, 9};

      clock              = 1'b0;
      reset              = 1'b1;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_valid          = 1'b0;
      req_volt_alpha     = '0;
      req_volt_beta      = '0;
      req_meas_cur_alpha = '0;
      req_meas_cur_beta  = '0;
      rsp_stall          = 1'b0;

      // After reset: unity retain, zero drive and zero gain, so every field
      // stays zero whatever the request carries.
      add_checked(32767, -32768, -32768, 32767, 0, 0, 0, 0, 0, 0);
      add_checked(-32768, 32767, 32767, -32768, 0, 0, 0, 0, 0, 0);
      add_checked(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // Zero retain and drive pin the estimate at zero, so the error is the
      // negated measurement; full gain and unity filter pass raw EMF through.
      add_write(smo_pkg::CSR_CURRENT_RETAIN, 24'd0);
      add_write(smo_pkg::CSR_SWITCH_GAIN, 24'd32767);
      add_write(smo_pkg::CSR_EMF_FILTER_FACTOR, 24'd65536);
      add_checked(0, 0, -32768, 32767, 0, 0, 32767, -32767, 32767, -32767);
      // error of exactly one ampere stays linear and lands on the full gain
      add_checked(0, 0, -1024, 1024, 0, 0, 32767, -32767, 32767, -32767);
      add_checked(0, 0, -1025, 1025, 0, 0, 32767, -32767, 32767, -32767);
      // one LSB of error: gain/1024 rounded half up
      add_checked(0, 0, -1, 1, 0, 0, 32, -32, 32, -32);
      // filter weight above one saturates to a pass-through
      add_write(smo_pkg::CSR_EMF_FILTER_FACTOR, 24'd131071);
      add_checked(32767, -32768, -2048, 2048, 0, 0, 32767, -32767, 32767, -32767);
      // writes to unlisted indexes change nothing
      add_write(CSR_UNUSED_LO, 24'hFFFFFF);
      add_write(CSR_UNUSED_HI, 24'h0);
      add_checked(0, 0, -1, 1, 0, 0, 32, -32, 32, -32);
      // retain above one with maximum drive: estimate overflow saturates
      add_write(smo_pkg::CSR_CURRENT_RETAIN, 24'd524287);
      add_write(smo_pkg::CSR_VOLTAGE_TO_CURRENT, 24'hFFFFFF);
      add_write(smo_pkg::CSR_EMF_FILTER_FACTOR, 24'd6554);
      add_item(32767, -32768, 0, 0);
      add_item(32767, -32768, 32767, -32768);
      add_item(-32768, 32767, -32768, 32767);
      add_item(0, 0, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].is_write) begin
            drain();
            write_reg(directed_rows[k].index, directed_rows[k].wdata);
         end else begin
            send_request(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].want);
         end
      end

      // Random phases; each starts from an empty pipeline with new registers
      // and cycles through the idling patterns.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         configure_phase(phase);
         send_idle_pct = idle_send[phase % 4];
         rsp_stall_pct = idle_rsp[phase % 4];
         // first phase: long receiver hold-off while requests keep coming,
         // so the block fills and stalls its input
         if (phase == 0)
            hold_left = HOLD_OFF_CYCLES;
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_request(random_request(), 1'b0, '0);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
